@@ rtl/avr_pkg.sv @@
// avr_pkg: shared constants, register codes and cordic arctangent table
// for the axis-angle vector rotation block; no dependencies
package avr_pkg;

    localparam int VEC_WIDTH_DEF      = 32;
    localparam int TRIG_FRAC_BITS_DEF = 16;
    localparam int AXIS_WIDTH         = 18;
    localparam int AXIS_FRAC          = 16;
    localparam int ANGLE_WIDTH        = 16;
    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int CORDIC_ITERS       = 30;
    localparam int CORDIC_FRAC        = 30;
    localparam int CORDIC_WIDTH       = 34;
    localparam int CORDIC_Z_WIDTH     = 33;
    localparam int ITER_WIDTH         = 5;
    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_Z = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE  = 2'd3;

    localparam logic signed [AXIS_WIDTH-1:0] AXIS_Z_RESET = 18'sd65536;

    function automatic logic signed [CORDIC_Z_WIDTH-1:0] atan_turn(input logic [ITER_WIDTH-1:0] i);
        logic signed [CORDIC_Z_WIDTH-1:0] r;
        case (i)
            5'd0:    r = 33'sd536870912;
            5'd1:    r = 33'sd316933406;
            5'd2:    r = 33'sd167458907;
            5'd3:    r = 33'sd85004756;
            5'd4:    r = 33'sd42667331;
            5'd5:    r = 33'sd21354465;
            5'd6:    r = 33'sd10679838;
            5'd7:    r = 33'sd5340245;
            5'd8:    r = 33'sd2670163;
            5'd9:    r = 33'sd1335087;
            5'd10:   r = 33'sd667544;
            5'd11:   r = 33'sd333772;
            5'd12:   r = 33'sd166886;
            5'd13:   r = 33'sd83443;
            5'd14:   r = 33'sd41722;
            5'd15:   r = 33'sd20861;
            5'd16:   r = 33'sd10430;
            5'd17:   r = 33'sd5215;
            5'd18:   r = 33'sd2608;
            5'd19:   r = 33'sd1304;
            5'd20:   r = 33'sd652;
            5'd21:   r = 33'sd326;
            5'd22:   r = 33'sd163;
            5'd23:   r = 33'sd81;
            5'd24:   r = 33'sd41;
            5'd25:   r = 33'sd20;
            5'd26:   r = 33'sd10;
            5'd27:   r = 33'sd5;
            5'd28:   r = 33'sd3;
            5'd29:   r = 33'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/axis_angle_vector_rotation.sv @@
// axis_angle_vector_rotation: rotates vectors about a unit axis by an angle
// one vector per cycle unless the output is stalled or the cordic is busy;
// three lanes share a dot-product merge stage; cordic on angle write
// holds s_axis_tready low while busy
// asynchronous active-low reset: axis (0,0,1), angle 0, cos 1, sin 0, pipe empty
module axis_angle_vector_rotation
    import avr_pkg::*;
#(
    parameter int VEC_WIDTH      = VEC_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // vec_x, vec_y, vec_z
    input  logic [((3*VEC_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // rot_x, rot_y, rot_z
    output logic [((3*VEC_WIDTH+7)/8)*8-1:0]            m_axis_tdata,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]                  cfg_index,
    input  logic [AXIS_WIDTH-1:0]                       cfg_data
);

    localparam int VW = VEC_WIDTH;
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int DW = ((3*VEC_WIDTH+7)/8)*8;

    logic signed [AXIS_WIDTH-1:0] ax_reg, ay_reg, az_reg;
    logic                         busy;
    logic signed [TW-1:0]         cos_val, sin_val;
    logic                         ce, cfg_we;
    logic [4:0]                   vld_reg, vld_next;
    logic signed [VW-1:0]         vx, vy, vz, rx, ry, rz;
    logic signed [VW+1:0]         dtx, dty, dtz;
    logic signed [VW+3:0]         dot_reg;
    logic signed [TW:0]           omc;
    logic signed [VW+4+TW:0]      pp;
    logic signed [VW+6:0]         p_reg;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            az_reg <= AXIS_Z_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AXIS_X: ax_reg <= cfg_data;
                REG_AXIS_Y: ay_reg <= cfg_data;
                REG_AXIS_Z: az_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    avr_trig #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_we && cfg_index == REG_ANGLE),
        .angle   (cfg_data[ANGLE_WIDTH-1:0]),
        .busy    (busy),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    assign ce            = !vld_reg[4] || m_axis_tready;
    assign s_axis_tready = ce && !busy;
    assign vld_next      = {vld_reg[3:0], s_axis_tvalid && s_axis_tready};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= vld_next;
    end

    assign vx = s_axis_tdata[VW-1:0];
    assign vy = s_axis_tdata[2*VW-1:VW];
    assign vz = s_axis_tdata[3*VW-1:2*VW];

    // dot merge and scaling by one minus cosine
    always_comb
    begin
        omc = (TW+1)'(1 << TRIG_FRAC_BITS) - (TW+1)'(cos_val);
        pp  = dot_reg * omc;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dot_reg <= (VW+4)'(dtx) + (VW+4)'(dty) + (VW+4)'(dtz);
            p_reg   <= pp[VW+4+TW:TRIG_FRAC_BITS];
        end
    end

    avr_lane #(.VEC_WIDTH(VW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_lane_x (
        .clk(clk), .ce(ce), .vi(vx), .vj(vy), .vk(vz),
        .ai(ax_reg), .aj(ay_reg), .ak(az_reg),
        .cos_val(cos_val), .sin_val(sin_val), .p_val(p_reg),
        .dot_term(dtx), .rot(rx)
    );

    avr_lane #(.VEC_WIDTH(VW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_lane_y (
        .clk(clk), .ce(ce), .vi(vy), .vj(vz), .vk(vx),
        .ai(ay_reg), .aj(az_reg), .ak(ax_reg),
        .cos_val(cos_val), .sin_val(sin_val), .p_val(p_reg),
        .dot_term(dty), .rot(ry)
    );

    avr_lane #(.VEC_WIDTH(VW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_lane_z (
        .clk(clk), .ce(ce), .vi(vz), .vj(vx), .vk(vy),
        .ai(az_reg), .aj(ax_reg), .ak(ay_reg),
        .cos_val(cos_val), .sin_val(sin_val), .p_val(p_reg),
        .dot_term(dtz), .rot(rz)
    );

    assign m_axis_tvalid = vld_reg[4];
    assign m_axis_tdata  = DW'({rz, ry, rx});

endmodule

@@ rtl/avr_trig.sv @@
// avr_trig: iterative cordic producing cosine and sine of the binary angle
// depends on avr_pkg
module avr_trig
    import avr_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ANGLE_WIDTH-1:0]        angle,
    output logic                          busy,
    output logic signed [TRIG_FRAC_BITS+1:0] cos_val,
    output logic signed [TRIG_FRAC_BITS+1:0] sin_val
);

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int RS = CORDIC_FRAC - TRIG_FRAC_BITS;
    localparam logic signed [CORDIC_WIDTH-1:0] HALF = CORDIC_WIDTH'(1) <<< (RS - 1);
    localparam logic signed [TW:0] TMAX = (TW+1)'((2 << TRIG_FRAC_BITS) - 1);
    localparam logic signed [TW:0] TMIN = -TMAX - (TW+1)'(1);
    localparam logic signed [TW-1:0] ONE = TW'(1 << TRIG_FRAC_BITS);

    logic                             busy_reg, busy_next;
    logic                             zero_reg, zero_next;
    logic [1:0]                       quad_reg, quad_next;
    logic [ITER_WIDTH-1:0]            iter_reg, iter_next;
    logic signed [CORDIC_WIDTH-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [CORDIC_Z_WIDTH-1:0] z_reg, z_next;
    logic signed [TW-1:0]             cos_reg, cos_next, sin_reg, sin_next;

    function automatic logic signed [TW-1:0] sat_tw(input logic signed [CORDIC_WIDTH-1:0] v);
        logic signed [TW-1:0] r;
        if (v > CORDIC_WIDTH'(TMAX))
            r = TMAX[TW-1:0];
        else if (v < CORDIC_WIDTH'(TMIN))
            r = TMIN[TW-1:0];
        else
            r = v[TW-1:0];
        return r;
    endfunction

    logic signed [CORDIC_WIDTH-1:0] dx, dy, xr, yr;
    logic signed [TW-1:0]           c0, s0;
    logic signed [CORDIC_WIDTH-1:0] c0w, s0w;

    always_comb
    begin
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        xr = (x_reg + HALF) >>> RS;
        yr = (y_reg + HALF) >>> RS;
        if (zero_reg)
        begin
            c0 = ONE;
            s0 = '0;
        end
        else
        begin
            c0 = sat_tw(xr);
            s0 = sat_tw(yr);
        end
        c0w = CORDIC_WIDTH'(c0);
        s0w = CORDIC_WIDTH'(s0);

        busy_next = busy_reg;
        zero_next = zero_reg;
        quad_next = quad_reg;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cos_next  = cos_reg;
        sin_next  = sin_reg;

        if (start)
        begin
            busy_next = 1'b1;
            quad_next = angle[ANGLE_WIDTH-1 -: 2];
            zero_next = (angle[ANGLE_WIDTH-3:0] == '0);
            iter_next = '0;
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = CORDIC_Z_WIDTH'(angle[ANGLE_WIDTH-3:0]) <<< 16;
        end
        else if (busy_reg)
        begin
            if (zero_reg || iter_reg == ITER_WIDTH'(CORDIC_ITERS))
            begin
                busy_next = 1'b0;
                case (quad_reg)
                    2'd0:
                    begin
                        cos_next = c0;
                        sin_next = s0;
                    end
                    2'd1:
                    begin
                        cos_next = sat_tw(-s0w);
                        sin_next = c0;
                    end
                    2'd2:
                    begin
                        cos_next = sat_tw(-c0w);
                        sin_next = sat_tw(-s0w);
                    end
                    default:
                    begin
                        cos_next = s0;
                        sin_next = sat_tw(-c0w);
                    end
                endcase
            end
            else
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_turn(iter_reg);
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_turn(iter_reg);
                end
                iter_next = iter_reg + ITER_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            zero_reg <= 1'b1;
            quad_reg <= '0;
            iter_reg <= '0;
            cos_reg  <= ONE;
            sin_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            zero_reg <= zero_next;
            quad_reg <= quad_next;
            iter_reg <= iter_next;
            cos_reg  <= cos_next;
            sin_reg  <= sin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy    = busy_reg;
    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

@@ rtl/avr_lane.sv @@
// avr_lane: one output component of the rotation, five register stages
// depends on avr_pkg
module avr_lane
    import avr_pkg::*;
#(
    parameter int VEC_WIDTH      = VEC_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             ce,
    input  logic signed [VEC_WIDTH-1:0]      vi,
    input  logic signed [VEC_WIDTH-1:0]      vj,
    input  logic signed [VEC_WIDTH-1:0]      vk,
    input  logic signed [AXIS_WIDTH-1:0]     ai,
    input  logic signed [AXIS_WIDTH-1:0]     aj,
    input  logic signed [AXIS_WIDTH-1:0]     ak,
    input  logic signed [TRIG_FRAC_BITS+1:0] cos_val,
    input  logic signed [TRIG_FRAC_BITS+1:0] sin_val,
    input  logic signed [VEC_WIDTH+6:0]      p_val,
    output logic signed [VEC_WIDTH+1:0]      dot_term,
    output logic signed [VEC_WIDTH-1:0]      rot
);

    localparam int VW = VEC_WIDTH;
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int SW = VW + 10;
    localparam logic signed [SW-1:0] VMAX = SW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

    logic signed [VW+AXIS_WIDTH-1:0] pd, pm1, pm2;
    logic signed [VW+TW-1:0]         pcv;
    logic signed [VW+1:0]            dt_reg, m1_reg, m2_reg, cv1_reg, cv2_reg, cv3_reg, cv4_reg;
    logic signed [VW+2:0]            cross_reg;
    logic signed [VW+2+TW:0]         pcs;
    logic signed [VW+4:0]            cs3_reg, cs4_reg;
    logic signed [VW+6+AXIS_WIDTH:0] ppa;
    logic signed [VW+8:0]            pa4_reg;
    logic signed [SW-1:0]            sum;
    logic signed [VW-1:0]            rot_reg;

    always_comb
    begin
        pd  = vi * ai;
        pm1 = vk * aj;
        pm2 = vj * ak;
        pcv = vi * cos_val;
        pcs = cross_reg * sin_val;
        ppa = p_val * ai;
        sum = SW'(cv4_reg) + SW'(cs4_reg) + SW'(pa4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dt_reg    <= pd[VW+AXIS_WIDTH-1:AXIS_FRAC];
            m1_reg    <= pm1[VW+AXIS_WIDTH-1:AXIS_FRAC];
            m2_reg    <= pm2[VW+AXIS_WIDTH-1:AXIS_FRAC];
            cv1_reg   <= pcv[VW+TW-1:TRIG_FRAC_BITS];
            cross_reg <= (VW+3)'(m1_reg) - (VW+3)'(m2_reg);
            cv2_reg   <= cv1_reg;
            cs3_reg   <= pcs[VW+2+TW:TRIG_FRAC_BITS];
            cv3_reg   <= cv2_reg;
            pa4_reg   <= ppa[VW+6+AXIS_WIDTH:AXIS_FRAC];
            cs4_reg   <= cs3_reg;
            cv4_reg   <= cv3_reg;
            if (sum > VMAX)
                rot_reg <= VMAX[VW-1:0];
            else if (sum < VMIN)
                rot_reg <= VMIN[VW-1:0];
            else
                rot_reg <= sum[VW-1:0];
        end
    end

    assign dot_term = dt_reg;
    assign rot      = rot_reg;

endmodule

@@ rtl/avr_checker.sv @@
// avr_checker: port-level assertions for axis_angle_vector_rotation
// depends on avr_pkg; bound to the top level
module avr_checker
    import avr_pkg::*;
#(
    parameter int DW = 96
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [DW-1:0]              m_axis_tdata,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [CFG_INDEX_WIDTH-1:0] cfg_index
);

    // stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output payload changed under stall");

    // input not taken while output is stuck
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // angle write blocks input while trig is recomputed
    a_angle_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == REG_ANGLE |=> !s_axis_tready)
        else $error("input accepted during trig update");

    // nothing valid while reset is held
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid || rst_n)
        else $error("output valid out of reset");

endmodule

bind axis_angle_vector_rotation avr_checker #(
    .DW(((3*VEC_WIDTH+7)/8)*8)
) u_avr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index)
);
